FILE: sv/lpg_pkg.sv
package lpg_pkg;

	// payload widths
	localparam int ELAPSED_W   = 24;
	localparam int PHASE_W     = 16;
	localparam int LED_BITS_W  = 8;
	localparam int MODE_W      = 4;
	localparam int MODES_W     = 32;
	localparam int BTN_IDX_W   = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	// default number of fitted leds
	localparam int LED_COUNT_DEF = 8;

	// elapsed / 100 as (elapsed >> 2) / 25, the /25 by reciprocal multiply
	localparam int QUART_W   = ELAPSED_W - 2;
	localparam int DIV_MUL_W = 23;
	localparam int DIV_SHIFT = 27;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 23'd5368710;
	localparam int PROD_W    = QUART_W + DIV_MUL_W;

	// half-brightness thresholds
	localparam logic [4:0] HALF_BUTTON  = 5'd26;
	localparam logic [4:0] HALF_DEFAULT = 5'd28;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LED_MODES        = 4'd0,
		REG_BUTTON_LED_INDEX = 4'd1
	} cfg_reg_t;

	// per-led pattern modes
	typedef enum logic [MODE_W-1:0] {
		MODE_OFF           = 4'd0,
		MODE_ON            = 4'd1,
		MODE_HALF          = 4'd2,
		MODE_BLINK_SLOW    = 4'd3,
		MODE_BLINK_MEDIUM  = 4'd4,
		MODE_BLINK_FAST    = 4'd5,
		MODE_FADE_SLOWEST  = 4'd6,
		MODE_FADE_SLOW     = 4'd7,
		MODE_FADE_MEDIUM   = 4'd8,
		MODE_FADE_FAST     = 4'd9,
		MODE_FADE_FASTER   = 4'd10,
		MODE_FADE_FASTEST  = 4'd11
	} led_mode_t;

	// on state of one led for phase p
	function automatic logic led_on(logic [MODE_W-1:0] mode, logic is_button,
			logic [PHASE_W-1:0] p);
		logic [16:0] d6;
		logic [14:0] d7;
		logic [13:0] d8;
		logic [12:0] d9;
		logic [10:0] d10;
		logic [9:0]  d11;
		logic        on;
		// triangle distances from the midpoint of each fade period
		d6  = p[15] ? ({1'b0, p} - 17'd32768) : (17'd32768 - {1'b0, p});
		d7  = p[14] ? (p[14:0] - 15'd16384) : (15'd16384 - p[14:0]);
		d8  = p[13] ? (p[13:0] - 14'd8192) : (14'd8192 - p[13:0]);
		d9  = p[12] ? (p[12:0] - 13'd4096) : (13'd4096 - p[12:0]);
		d10 = p[10] ? (p[10:0] - 11'd1024) : (11'd1024 - p[10:0]);
		d11 = p[9] ? (p[9:0] - 10'd512) : (10'd512 - p[9:0]);
		case (mode)
			MODE_ON:           on = 1'b1;
			MODE_HALF:         on = p[4:0] > (is_button ? HALF_BUTTON : HALF_DEFAULT);
			MODE_BLINK_SLOW:   on = p[12:0] > 13'd4096;
			MODE_BLINK_MEDIUM: on = p[11:0] > 12'd2048;
			MODE_BLINK_FAST:   on = p[10:0] > 11'd1024;
			MODE_FADE_SLOWEST: on = {2'b00, p[5:0]} > d6[16:9];
			MODE_FADE_SLOW:    on = {1'b0, p[5:0]} > d7[14:8];
			MODE_FADE_MEDIUM:  on = {1'b0, p[4:0]} > d8[13:8];
			MODE_FADE_FAST:    on = {1'b0, p[3:0]} > d9[12:8];
			MODE_FADE_FASTER:  on = {1'b0, p[3:0]} > d10[10:6];
			MODE_FADE_FASTEST: on = {1'b0, p[3:0]} > d11[9:5];
			default:           on = 1'b0;
		endcase
		return on;
	endfunction

endpackage

FILE: sv/lpg_ifs.sv
// tick channel: one elapsed time per transfer
interface lpg_tick_if;
	logic                            valid;
	logic                            ready;
	logic [lpg_pkg::ELAPSED_W-1:0]   elapsed_time;
	modport source (output valid, output elapsed_time, input ready);
	modport sink (input valid, input elapsed_time, output ready);
endinterface

// result channel: all led bits per transfer
interface lpg_leds_if;
	logic                            valid;
	logic                            ready;
	logic [lpg_pkg::LED_BITS_W-1:0]  led_bits;
	modport source (output valid, output led_bits, input ready);
	modport sink (input valid, input led_bits, output ready);
endinterface

// configuration write channel
interface lpg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lpg_pkg::CFG_INDEX_W-1:0] index;
	logic [lpg_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/led_pattern_generator.sv
// LED pattern generator: each tick transfer carries the time elapsed since the last tick;
// a 16-bit wrapping phase advances by elapsed_time / 100 and every LED's on bit is derived
// from the new phase and its 4-bit mode in led_modes (off, on, half brightness, three blink
// rates, six triangle fades; codes 12 to 15 are off). One led_bits result per tick. The block
// takes one tick per clock cycle while the result side is not stalled; each tick passes through
// the input register, the reciprocal multiply register and the output register. A stall on
// the result side backs up through these three stages. Configuration writes are always ready
// and are meant to happen only while no tick is in flight.
module led_pattern_generator #(
	parameter int LED_COUNT = lpg_pkg::LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lpg_tick_if.sink    tick,
	lpg_leds_if.source  leds,
	lpg_cfg_if.sink     cfg
);

	logic                                  v_s1, v_s2, v_s3;
	logic                                  en1, en2, en3;
	logic [lpg_pkg::ELAPSED_W-1:0]         elapsed_s1;
	logic [lpg_pkg::PROD_W-1:0]            prod;
	logic [lpg_pkg::PHASE_W-1:0]           incr_s2;
	logic [lpg_pkg::PHASE_W-1:0]           phase_q;
	logic [lpg_pkg::PHASE_W-1:0]           phase_next;
	logic [lpg_pkg::LED_BITS_W-1:0]        bits;
	logic [lpg_pkg::LED_BITS_W-1:0]        led_bits_s3;
	logic [lpg_pkg::MODES_W-1:0]           led_modes_q;
	logic [lpg_pkg::BTN_IDX_W-1:0]         button_led_index_q;

	// stage enables, a stage moves when the one after it has room
	assign en3 = !v_s3 || leds.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign tick.ready = en1;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_modes_q <= '0;
			button_led_index_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				lpg_pkg::REG_LED_MODES:        led_modes_q <= cfg.data;
				lpg_pkg::REG_BUTTON_LED_INDEX: button_led_index_q <=
						cfg.data[lpg_pkg::BTN_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= tick.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && tick.valid) elapsed_s1 <= tick.elapsed_time;
	end

	// divide by 100: quarter the value, then multiply by the reciprocal of 25
	assign prod = lpg_pkg::PROD_W'(elapsed_s1[lpg_pkg::ELAPSED_W-1:2]) *
			lpg_pkg::PROD_W'(lpg_pkg::DIV_MUL);

	always_ff @(posedge clk) begin
		if (en2 && v_s1)
			incr_s2 <= prod[lpg_pkg::DIV_SHIFT +: lpg_pkg::PHASE_W];
	end

	// phase update, wraps modulo 2^16
	assign phase_next = phase_q + incr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (en3 && v_s2) begin
			phase_q <= phase_next;
		end
	end

	// per-led pattern evaluation on the updated phase
	for (genvar i = 0; i < lpg_pkg::LED_BITS_W; i++) begin : g_led
		if (i < LED_COUNT) begin : g_fit
			assign bits[i] = lpg_pkg::led_on(led_modes_q[4*i +: lpg_pkg::MODE_W],
					button_led_index_q == lpg_pkg::BTN_IDX_W'(i), phase_next);
		end else begin : g_none
			assign bits[i] = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en3 && v_s2) led_bits_s3 <= bits;
	end

	assign leds.valid = v_s3;
	assign leds.led_bits = led_bits_s3;

	// phase only moves when an item passes into the output stage
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en3 && v_s2) |=> $stable(phase_q))
		else $error("phase changed without an item");

	// phase advances by the registered increment
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2) |=> phase_q == $past(phase_next))
		else $error("phase step wrong");

	// tick side stalls only with every stage full and the result stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> (v_s1 && v_s2 && v_s3 && !leds.ready))
		else $error("tick stalled with room in the pipeline");

	// leds beyond the fitted count stay dark
	a_unfitted_dark: assert property (@(posedge clk) disable iff (!arst_n)
		leds.valid |-> (leds.led_bits >> LED_COUNT) == '0)
		else $error("unfitted led lit");

endmodule
